@@ sv/mpe_pkg.sv @@
package mpe_pkg;
  localparam int NUM_VARS_DEF  = 4;
  localparam int MAX_ORDER_DEF = 3;
  localparam int IN_VARS       = 4;
  localparam int STORE_SLOTS   = 64;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_CGRAD = 2'd1,
    KIND_VGRAD = 2'd2
  } kind_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic [1:0] MODE_CGRAD = 2'd1;
  localparam logic [1:0] MODE_VGRAD = 2'd2;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // exact product plus half, floor shift by 16, then saturate
  function automatic logic signed [31:0] qfix(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = (p + 64'sd32768) >>> 16;
    return sat32(s);
  endfunction
endpackage

@@ sv/multivariate_polynomial_eval.sv @@
// operation: a load is written at its accepting edge; an evaluate reads the constant
// term (S_RD, S_MONO), then for each further slot steps through S_RD, S_MONO, S_ACC,
// then S_OTH and S_GACC for each factor, then S_ADV, and presents the value beat in S_OUT
// throughput: one item at a time; mode 1 adds slot-count beats and mode 2 NUM_VARS beats
// reset: synchronous active high, then clears the store one slot per cycle, during
// which no item is accepted
module multivariate_polynomial_eval #(
  parameter int NUM_VARS  = mpe_pkg::NUM_VARS_DEF,
  parameter int MAX_ORDER = mpe_pkg::MAX_ORDER_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [5:0]         coeff_index,
  input  logic signed [31:0] coeff_value,
  input  logic [1:0]         mode,
  input  logic signed [31:0] var_0,
  input  logic signed [31:0] var_1,
  input  logic signed [31:0] var_2,
  input  logic signed [31:0] var_3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [5:0]         index,
  output logic signed [31:0] result,
  output logic               last
);
  import mpe_pkg::*;

  localparam longint BC1 = NUM_VARS + MAX_ORDER;
  localparam longint BC2 = (MAX_ORDER >= 2) ? BC1 * (NUM_VARS + MAX_ORDER - 1) / 2 : BC1;
  localparam longint BC3 = (MAX_ORDER >= 3) ? BC2 * (NUM_VARS + MAX_ORDER - 2) / 3 : BC2;
  localparam longint BC4 = (MAX_ORDER >= 4) ? BC3 * (NUM_VARS + MAX_ORDER - 3) / 4 : BC3;
  localparam longint BC5 = (MAX_ORDER >= 5) ? BC4 * (NUM_VARS + MAX_ORDER - 4) / 5 : BC4;
  localparam longint BC6 = (MAX_ORDER >= 6) ? BC5 * (NUM_VARS + MAX_ORDER - 5) / 6 : BC5;
  localparam int SLOTS = (BC6 > STORE_SLOTS) ? STORE_SLOTS : int'(BC6);
  localparam int SW    = 6;
  localparam int VW    = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int OW    = $clog2(MAX_ORDER + 2);
  localparam int CW    = $clog2(MAX_ORDER + 1) + 1;
  localparam int AW    = 72;

  function automatic logic signed [31:0] sat_wide(input logic signed [AW-1:0] v);
    if (v > AW'(64'sd2147483647)) return 32'sh7fffffff;
    if (v < -AW'(64'sd2147483648)) return 32'sh80000000;
    return v[31:0];
  endfunction

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RD    = 9'b000000100,
    S_MONO  = 9'b000001000,
    S_ACC   = 9'b000010000,
    S_OTH   = 9'b000100000,
    S_GACC  = 9'b001000000,
    S_ADV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic signed [31:0] mem [SLOTS];
  logic signed [31:0] rd_data;
  logic [SW-1:0] rd_addr, clr_addr;
  logic signed [31:0] cgrad [SLOTS];

  logic signed [31:0] vin [IN_VARS];
  logic signed [31:0] vars [NUM_VARS];
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] vgrad [NUM_VARS];
  logic [1:0] md;
  logic [SW-1:0] ip;
  logic [OW-1:0] io;
  logic [VW-1:0] ii [MAX_ORDER];
  logic [CW-1:0] k, j;
  logic first;
  logic signed [31:0] mono, oth, coef;
  logic [SW-1:0] oidx;
  logic [1:0] okind;
  logic out_fin;

  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  assign prod = ma * mb;

  assign vin[0] = var_0;
  assign vin[1] = var_1;
  assign vin[2] = var_2;
  assign vin[3] = var_3;

  assign in_ready = (state == S_IDLE);

  assign out_fin = !((okind == KIND_VALUE && (md == MODE_CGRAD || md == MODE_VGRAD)) ||
                     (okind == KIND_CGRAD && oidx != SW'(SLOTS - 1)) ||
                     (okind == KIND_VGRAD && oidx != SW'(NUM_VARS - 1)));

  always_ff @(posedge clk) begin
    if (state == S_CLR) begin
      mem[clr_addr] <= '0;
    end else if (in_valid && in_ready && command == CMD_LOAD &&
                 {1'b0, coeff_index} < (SW+1)'(SLOTS)) begin
      mem[coeff_index] <= coeff_value;
    end
    rd_data <= mem[rd_addr];
  end

  logic [VW-1:0] vsel;
  logic signed [31:0] vcur;
  always_comb begin
    vsel = ii[0];
    for (int t = 0; t < MAX_ORDER; t++) begin
      if (CW'(t) == k) vsel = ii[t];
    end
    vcur = vars[vsel];
    ma = mono;
    mb = vcur;
    if (state == S_ACC) begin
      ma = coef;
      mb = mono;
    end else if (state == S_OTH) begin
      ma = oth;
      mb = vcur;
    end else if (state == S_GACC) begin
      ma = coef;
      mb = oth;
    end
  end

  logic [VW-1:0] jsel;
  always_comb begin
    jsel = ii[0];
    for (int t = 0; t < MAX_ORDER; t++) begin
      if (CW'(t) == j) jsel = ii[t];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      out_valid <= 1'b0;
      rd_addr <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SW'(SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && command != CMD_LOAD) begin
            md <= mode;
            for (int t = 0; t < NUM_VARS; t++) begin
              vars[t] <= (t < IN_VARS) ? vin[t[1:0]] : '0;
            end
            for (int t = 0; t < NUM_VARS; t++) vgrad[t] <= '0;
            cgrad[0] <= Q_ONE;
            rd_addr <= '0;
            ip <= '0;
            io <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_MONO;
          k <= '0;
        end
        S_MONO: begin
          if (ip == '0) begin
            acc <= AW'(rd_data);
            ip <= SW'(1);
            io <= OW'(1);
            for (int t = 0; t < MAX_ORDER; t++) ii[t] <= '0;
            if (SLOTS > 1) begin
              rd_addr <= SW'(1);
              state <= S_RD;
            end else begin
              state <= S_OUT;
              oidx <= '0;
              okind <= KIND_VALUE;
            end
          end else begin
            coef <= rd_data;
            if (k == '0) mono <= vars[ii[0]];
            else mono <= qfix(prod);
            if (k + 1'b1 >= CW'(io)) begin
              state <= S_ACC;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        S_ACC: begin
          acc <= acc + AW'(qfix(prod));
          cgrad[ip] <= mono;
          j <= '0;
          k <= '0;
          first <= 1'b1;
          oth <= Q_ONE;
          state <= S_OTH;
        end
        S_OTH: begin
          if (k >= CW'(io)) begin
            state <= S_GACC;
          end else begin
            if (k != j) begin
              oth <= first ? vcur : qfix(prod);
              first <= 1'b0;
            end
            k <= k + 1'b1;
          end
        end
        S_GACC: begin
          vgrad[jsel] <= vgrad[jsel] + AW'(qfix(prod));
          if (j + 1'b1 >= CW'(io)) begin
            state <= S_ADV;
          end else begin
            j <= j + 1'b1;
            k <= '0;
            first <= 1'b1;
            oth <= Q_ONE;
            state <= S_OTH;
          end
        end
        S_ADV: begin : adv
          logic [CW-1:0] kc;
          logic done;
          logic [VW-1:0] nii [MAX_ORDER];
          kc = CW'(io);
          done = 1'b1;
          for (int t = 0; t < MAX_ORDER; t++) nii[t] = ii[t];
          for (int t = 0; t < MAX_ORDER; t++) begin
            if (done && CW'(t) < CW'(io)) begin
              if (int'(nii[t]) == NUM_VARS - 1) begin
                nii[t] = '0;
              end else begin
                nii[t] = nii[t] + 1'b1;
                kc = CW'(t);
                done = 1'b0;
              end
            end
          end
          for (int t = MAX_ORDER - 1; t >= 0; t--) begin
            if (CW'(t) < kc && !done) nii[t] = nii[t + 1 < MAX_ORDER ? t + 1 : t];
          end
          ip <= ip + 1'b1;
          if ({1'b0, ip} + 1'b1 >= (SW+1)'(SLOTS)) begin
            state <= S_OUT;
            oidx <= '0;
            okind <= KIND_VALUE;
          end else begin
            rd_addr <= ip + 1'b1;
            state <= S_RD;
            if (done) begin
              io <= io + 1'b1;
              for (int t = 0; t < MAX_ORDER; t++) ii[t] <= '0;
            end else begin
              for (int t = 0; t < MAX_ORDER; t++) ii[t] <= nii[t];
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            kind <= okind;
            index <= oidx;
            last <= out_fin;
            unique case (okind)
              KIND_VALUE: result <= sat_wide(acc);
              KIND_CGRAD: result <= cgrad[oidx];
              default:    result <= sat_wide(vgrad[oidx[VW-1:0]]);
            endcase
            if (okind == KIND_VALUE && md == MODE_CGRAD) begin
              okind <= KIND_CGRAD;
              oidx <= '0;
            end else if (okind == KIND_VALUE && md == MODE_VGRAD) begin
              okind <= KIND_VGRAD;
              oidx <= '0;
            end else if (okind == KIND_CGRAD && oidx != SW'(SLOTS - 1)) begin
              oidx <= oidx + 1'b1;
            end else if (okind == KIND_VGRAD && oidx != SW'(NUM_VARS - 1)) begin
              oidx <= oidx + 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state != S_OUT && out_valid && out_ready) out_valid <= 1'b0;
    end
  end
endmodule
